// ===== hdl/lbp_pkg.sv =====
// shared constants and types for the 3x3 local binary pattern block
// no dependencies; imported by lbp_3x3_code
`default_nettype none

package lbp_pkg;

  // line store depth default and the fixed frame height limit
  localparam int unsigned MaxWidthDef = 1024;
  localparam int unsigned MaxHeight   = 1024;

  // field widths
  localparam int unsigned PixW   = 8;
  localparam int unsigned CodeW  = 8;
  localparam int unsigned PosW   = 10;
  localparam int unsigned CfgW   = 11;
  localparam int unsigned CfgIdxW = 1;

  // packed widths on the stream ports
  localparam int unsigned SDataW = 8;
  localparam int unsigned MDataW = 32;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegImageWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 1'b1;

  // reset geometry
  localparam int unsigned ImageWidthRst  = 28;
  localparam int unsigned ImageHeightRst = 28;

  // metadata of one result item
  typedef struct packed {
    logic [PosW-1:0] centre_row;
    logic [PosW-1:0] centre_col;
    logic            last_in_frame;
  } lbp_meta_t;

  // one result item
  typedef struct packed {
    logic [CodeW-1:0] lbp_code;
    lbp_meta_t        meta;
  } lbp_result_t;

endpackage

`default_nettype wire

// ===== hdl/lbp_3x3_code.sv =====
// 3x3 local binary pattern unit: line stores, window taps and result buffering
// depends on lbp_pkg
`default_nettype none

// Usage
// Gray pixels enter in raster order on the s_axis channel, one item per
// pixel; tuser marks the first pixel of a frame and clears the row and
// column position. Each interior pixel gives one item on m_axis carrying
// its 8-bit code, its row and column, and tlast on the last interior code
// of the frame. Border pixels give nothing.
// A code leaves once the pixel below-right of its centre is accepted: the
// accept edge loads the stage 1 registers and the line store reads, and the
// result then loads into the output register, or into the skid on a stall.
// Throughput is one pixel per cycle while the skid is empty; the two line
// stores are read and written once per pixel, with a bypass for a frame
// restart that revisits an entry still being written back.
// Geometry is to be written on the cfg port while the block is idle (not
// enforced); values outside 3..MAX_WIDTH (width) or 3..1024 (height) are clamped.
// Reset clears position, window taps and sets the geometry to 28 x 28;
// the line stores are not cleared and need no clearing pass.
// When m_axis stalls, one result sits in the output register and one more
// in a skid register; s_axis_tready falls only once the skid is full.
module lbp_3x3_code
  import lbp_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MaxWidthDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // configuration writes
  input  wire                 cfg_we_i,
  input  wire [CfgIdxW-1:0]   cfg_idx_i,
  input  wire [CfgW-1:0]      cfg_data_i,
  // pixel stream in
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire [SDataW-1:0]    s_axis_tdata,   // [7:0] pixel
  input  wire                 s_axis_tuser,   // [0] frame_start
  // code stream out
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  output logic [MDataW-1:0]   m_axis_tdata,   // [7:0] lbp_code, [17:8] centre_row,
                                              // [27:18] centre_col, [31:28] zero
  output logic                m_axis_tlast    // last_in_frame
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned ExtW = (ColW + 1 > CfgW) ? ColW + 1 : CfgW;
  localparam int unsigned RowW = $clog2(MaxHeight);

  // geometry registers, held as last column and last row
  logic [ColW-1:0] wm1_q, wm1_d;
  logic [RowW-1:0] hm1_q, hm1_d;
  logic [ExtW-1:0] cfg_ext;

  // position of the next pixel
  logic [ColW-1:0] col_q, col_d, col0;
  logic [RowW-1:0] row_q, row_d, row0;

  // pipeline control
  logic en, accept, wr_en;

  // stage 1 registers
  logic             s1_valid_q;
  logic             s1_int_q;
  logic [PixW-1:0]  s1_px_q;
  logic [ColW-1:0]  s1_idx_q;
  lbp_meta_t        s1_meta_q;
  lbp_meta_t        meta0;

  // line stores and their read registers
  logic [PixW-1:0] store_a [MAX_WIDTH];
  logic [PixW-1:0] store_b [MAX_WIDTH];
  logic [PixW-1:0] rd_a_q, rd_b_q;
  logic            fwd_q;
  logic [PixW-1:0] fwd_a_q, fwd_b_q;
  logic [PixW-1:0] above, above2;

  // window taps: columns 0 and 1 of rows top, middle, bottom
  logic [PixW-1:0] win_q [6];
  logic [PixW-1:0] nb [8];
  logic [PixW-1:0] centre;
  logic [CodeW-1:0] code;

  // output register and skid
  logic        out_valid_q, skid_valid_q;
  lbp_result_t out_q, skid_q, res_new;
  logic        take, new_res;

  // clamp and store geometry on a config write
  assign cfg_ext = ExtW'(cfg_data_i);

  always_comb begin
    wm1_d = wm1_q;
    hm1_d = hm1_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegImageWidth: begin
          if (cfg_ext < ExtW'(3)) begin
            wm1_d = ColW'(2);
          end else if (cfg_ext > ExtW'(MAX_WIDTH)) begin
            wm1_d = ColW'(MAX_WIDTH - 1);
          end else begin
            wm1_d = ColW'(cfg_ext - ExtW'(1));
          end
        end
        RegImageHeight: begin
          if (cfg_data_i < CfgW'(3)) begin
            hm1_d = RowW'(2);
          end else if (cfg_data_i > CfgW'(MaxHeight)) begin
            hm1_d = RowW'(MaxHeight - 1);
          end else begin
            hm1_d = RowW'(cfg_data_i - CfgW'(1));
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm1_q <= ColW'(ImageWidthRst - 1);
      hm1_q <= RowW'(ImageHeightRst - 1);
    end else begin
      wm1_q <= wm1_d;
      hm1_q <= hm1_d;
    end
  end

  // handshake: the pipeline moves unless the skid holds a result
  assign en            = !skid_valid_q;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;
  assign wr_en         = en && s1_valid_q;

  // position of the incoming pixel and the next one
  always_comb begin
    col0 = s_axis_tuser ? '0 : col_q;
    row0 = s_axis_tuser ? '0 : row_q;
    if (col0 >= wm1_q) begin
      col_d = '0;
      row_d = (row0 >= hm1_q) ? '0 : row0 + RowW'(1);
    end else begin
      col_d = col0 + ColW'(1);
      row_d = row0;
    end
    meta0.centre_row    = PosW'(row0 - RowW'(1));
    meta0.centre_col    = PosW'(col0 - ColW'(1));
    meta0.last_in_frame = (row0 == hm1_q) && (col0 == wm1_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q   <= s_axis_tdata[PixW-1:0];
      s1_idx_q  <= col0;
      s1_int_q  <= (row0 >= RowW'(2)) && (col0 >= ColW'(2));
      s1_meta_q <= meta0;
    end
  end

  // line stores: read on accept, written back from the stage 1 registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_a_q <= store_a[col0];
      rd_b_q <= store_b[col0];
    end
    if (wr_en) begin
      store_a[s1_idx_q] <= s1_px_q;
      store_b[s1_idx_q] <= above;
    end
  end

  // bypass when a read hits the entry being written back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (accept) begin
      fwd_q <= s1_valid_q && (s1_idx_q == col0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_a_q <= s1_px_q;
      fwd_b_q <= above;
    end
  end

  assign above  = fwd_q ? fwd_a_q : rd_a_q;
  assign above2 = fwd_q ? fwd_b_q : rd_b_q;

  // window after the shift, neighbours in raster order
  always_comb begin
    nb[0]  = win_q[0];
    nb[1]  = win_q[1];
    nb[2]  = above2;
    nb[3]  = win_q[2];
    nb[4]  = above;
    nb[5]  = win_q[4];
    nb[6]  = win_q[5];
    nb[7]  = s1_px_q;
    centre = win_q[3];
    for (int k = 0; k < 8; k++) begin
      code[k] = (centre <= nb[k]);
    end
  end

  // window shift on each pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (wr_en) begin
      win_q[0] <= win_q[1];
      win_q[1] <= above2;
      win_q[2] <= win_q[3];
      win_q[3] <= above;
      win_q[4] <= win_q[5];
      win_q[5] <= s1_px_q;
    end
  end

  // result into output register or skid
  assign take             = out_valid_q && m_axis_tready;
  assign new_res          = wr_en && s1_int_q;
  assign res_new.lbp_code = code;
  assign res_new.meta     = s1_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (new_res) begin
      out_valid_q <= 1'b1;
      if (out_valid_q && !take) begin
        skid_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (new_res) begin
      if (!out_valid_q || take) begin
        out_q <= res_new;
      end else begin
        skid_q <= res_new;
      end
    end
  end

  // output packing
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q.meta.centre_col, out_q.meta.centre_row,
                          out_q.lbp_code};
  assign m_axis_tlast  = out_q.meta.last_in_frame;

endmodule

`default_nettype wire
